// ===== rtl/lhe_pkg.sv =====
`timescale 1ns / 1ps
package lhe_pkg;

   // frame and window limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_RADIUS = 7;
   localparam int WIN_MAX    = 2 * MAX_RADIUS + 1;
   localparam int DEPTH      = WIN_MAX * MAX_WIDTH;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int PEND_W     = $clog2(DEPTH + 1);
   localparam int CNT_W      = $clog2(WIN_MAX * WIN_MAX + 1);
   localparam int STEP_W     = $clog2(WIN_MAX);
   localparam int REM_W      = CNT_W + 8;

   // configuration register fields
   localparam int WIDTH_W  = 11;
   localparam int HEIGHT_W = 12;
   localparam int RADIUS_W = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_RADIUS = 2'd2;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef struct packed {
      logic       op;
      logic [7:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [7:0] pixel_out;
      logic       frame_last;
   } rsp_type;

   // circular address step forward, both operands below DEPTH
   function automatic logic [ADDR_W-1:0] addr_add(input logic [ADDR_W-1:0] a,
                                                  input logic [ADDR_W-1:0] b);
      logic [ADDR_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (ADDR_W+1)'(DEPTH)) begin
         s = s - (ADDR_W+1)'(DEPTH);
      end
      return s[ADDR_W-1:0];
   endfunction

   // circular address step backward, both operands below DEPTH
   function automatic logic [ADDR_W-1:0] addr_sub(input logic [ADDR_W-1:0] a,
                                                  input logic [ADDR_W-1:0] b);
      logic [ADDR_W:0] s;
      s = {1'b0, a} - {1'b0, b};
      if (a < b) begin
         s = s + (ADDR_W+1)'(DEPTH);
      end
      return s[ADDR_W-1:0];
   endfunction

   // pixels in the window, (2m+1)^2
   function automatic logic [CNT_W-1:0] win_size(input logic [RADIUS_W-1:0] m);
      logic [STEP_W-1:0] d;
      d = {m, 1'b1};
      return CNT_W'(d) * CNT_W'(d);
   endfunction

endpackage

// ===== rtl/local_histogram_equalize_core.sv =====
`timescale 1ns / 1ps
// Local histogram equalisation over a sliding (2m+1)x(2m+1) window of 8-bit
// grey pixels in raster order. Each interior pixel becomes
// floor(255*count/N), count being the window pixels not above the centre;
// pixels within m of an edge pass through. Results lag the input by m*W+m
// pixels; drain items flush the tail and frame_last marks the final pixel.
// A border result needs only the centre pixel read; an interior result is paced
// by the single read port of the 15-line store, which fetches one window
// pixel per cycle, followed by an 8-step shift-subtract divider. The result
// sits in an output register, so the next item is taken while it waits.
// Configuration writes are taken at any time but must be made while idle.
module local_histogram_equalize_core
   import lhe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_RDC  = 6'b000010,
      S_CAP  = 6'b000100,
      S_WIN  = 6'b001000,
      S_DIV  = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

   // configuration registers
   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [RADIUS_W-1:0] radius_ff;

   // control and datapath registers
   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   wr_addr_ff, wr_addr_in;
   logic [PEND_W-1:0]   pending_ff, pending_in;
   logic [WIDTH_W-1:0]  out_col_ff, out_col_in;
   logic [HEIGHT_W-1:0] out_row_ff, out_row_in;
   logic [ADDR_W-1:0]   base_ff, base_in;
   logic [ADDR_W-1:0]   row_start_ff, row_start_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [STEP_W-1:0]   win_col_ff, win_col_in;
   logic [STEP_W-1:0]   win_row_ff, win_row_in;
   logic                issue_done_ff, issue_done_in;
   logic                cmp_valid_ff, cmp_valid_in;
   logic [7:0]          centre_ff, centre_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [7:0]          quot_ff, quot_in;
   logic [2:0]          bit_ff, bit_in;
   logic                interior_ff, interior_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   // line store
   logic [7:0]          mem [DEPTH];
   logic [7:0]          rd_data_ff;
   logic                mem_we;
   logic                mem_re;
   logic [ADDR_W-1:0]   mem_raddr;

   // effective geometry
   logic [WIDTH_W-1:0]  eff_w;
   logic [HEIGHT_W-1:0] eff_h;
   logic [ADDR_W-1:0]   lag;
   logic [CNT_W-1:0]    n_win;
   logic [STEP_W-1:0]   span;
   logic                interior;
   logic                frame_last;

   logic                req_xfer;
   logic [PEND_W-1:0]   pend_next;
   logic [ADDR_W-1:0]   wr_next;
   logic                do_emit;
   logic [CNT_W-1:0]    count_fin;
   logic [REM_W-1:0]    div_sub;
   logic [WIDTH_W:0]    col_inc;
   logic [HEIGHT_W:0]   row_inc;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_W'(640);
         height_ff <= HEIGHT_W'(480);
         radius_ff <= RADIUS_W'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:   width_ff  <= csr_wdata[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT:  height_ff <= csr_wdata[HEIGHT_W-1:0];
            CSR_WINDOW_RADIUS: radius_ff <= csr_wdata[RADIUS_W-1:0];
            default: ;
         endcase
      end
   end

   // clamped geometry and window figures
   always_comb begin
      if (width_ff == '0) begin
         eff_w = WIDTH_W'(1);
      end else if (width_ff > WIDTH_W'(MAX_WIDTH)) begin
         eff_w = WIDTH_W'(MAX_WIDTH);
      end else begin
         eff_w = width_ff;
      end
      eff_h = (height_ff == '0) ? HEIGHT_W'(1) : height_ff;
      lag   = ADDR_W'(ADDR_W'(radius_ff) * ADDR_W'(eff_w)) + ADDR_W'(radius_ff);
      n_win = win_size(radius_ff);
      span  = STEP_W'({radius_ff, 1'b0});
      interior = (out_row_ff >= HEIGHT_W'(radius_ff))
              && (({1'b0, out_row_ff} + (HEIGHT_W+1)'(radius_ff)) < {1'b0, eff_h})
              && (out_col_ff >= WIDTH_W'(radius_ff))
              && (({1'b0, out_col_ff} + (WIDTH_W+1)'(radius_ff)) < {1'b0, eff_w});
      frame_last = (out_row_ff == eff_h - HEIGHT_W'(1)) && (out_col_ff == eff_w - WIDTH_W'(1));
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      wr_addr_in    = wr_addr_ff;
      pending_in    = pending_ff;
      out_col_in    = out_col_ff;
      out_row_in    = out_row_ff;
      base_in       = base_ff;
      row_start_in  = row_start_ff;
      addr_in       = addr_ff;
      win_col_in    = win_col_ff;
      win_row_in    = win_row_ff;
      issue_done_in = issue_done_ff;
      cmp_valid_in  = 1'b0;
      centre_in     = centre_ff;
      count_in      = count_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      bit_in        = bit_ff;
      interior_in   = interior_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_raddr     = addr_ff;
      pend_next     = pending_ff;
      wr_next       = wr_addr_ff;
      do_emit       = 1'b0;
      count_fin     = count_ff;
      div_sub       = REM_W'(n_win) << bit_ff;
      col_inc       = {1'b0, out_col_ff} + (WIDTH_W+1)'(1);
      row_inc       = {1'b0, out_row_ff} + (HEIGHT_W+1)'(1);

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if (req_data.op == OP_PIXEL) begin
                  mem_we    = 1'b1;
                  wr_next   = addr_add(wr_addr_ff, ADDR_W'(1));
                  pend_next = (pending_ff < PEND_W'(DEPTH)) ? pending_ff + PEND_W'(1)
                                                           : pending_ff;
                  do_emit   = (pend_next > PEND_W'(lag));
               end else begin
                  do_emit = (pending_ff != '0)
                         && ((pending_ff > PEND_W'(lag)) || !interior);
               end
               wr_addr_in = wr_next;
               pending_in = pend_next;
               if (do_emit) begin
                  base_in     = addr_sub(wr_next, pend_next[ADDR_W-1:0]);
                  interior_in = interior;
                  state_in    = S_RDC;
               end
            end
         end
         S_RDC: begin
            // fetch the centre pixel
            mem_re    = 1'b1;
            mem_raddr = base_ff;
            state_in  = S_CAP;
         end
         S_CAP: begin
            centre_in = rd_data_ff;
            if (interior_ff) begin
               row_start_in  = addr_sub(base_ff, lag);
               addr_in       = addr_sub(base_ff, lag);
               win_col_in    = '0;
               win_row_in    = '0;
               count_in      = '0;
               issue_done_in = 1'b0;
               state_in      = S_WIN;
            end else begin
               quot_in  = rd_data_ff;
               state_in = S_OUT;
            end
         end
         S_WIN: begin
            // one window pixel read and one compare per cycle
            if (cmp_valid_ff && (rd_data_ff <= centre_ff)) begin
               count_fin = count_ff + CNT_W'(1);
            end
            count_in = count_fin;
            if (!issue_done_ff) begin
               mem_re       = 1'b1;
               cmp_valid_in = 1'b1;
               if (win_col_ff == span) begin
                  win_col_in   = '0;
                  win_row_in   = win_row_ff + STEP_W'(1);
                  row_start_in = addr_add(row_start_ff, ADDR_W'(eff_w));
                  addr_in      = addr_add(row_start_ff, ADDR_W'(eff_w));
                  if (win_row_ff == span) begin
                     issue_done_in = 1'b1;
                  end
               end else begin
                  win_col_in = win_col_ff + STEP_W'(1);
                  addr_in    = addr_add(addr_ff, ADDR_W'(1));
               end
            end else if (!cmp_valid_ff) begin
               rem_in   = (REM_W'(count_ff) << 8) - REM_W'(count_ff);
               quot_in  = '0;
               bit_in   = 3'd7;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // restoring division, one quotient bit per cycle
            if (rem_ff >= div_sub) begin
               rem_in          = rem_ff - div_sub;
               quot_in[bit_ff] = 1'b1;
            end
            bit_in = bit_ff - 3'd1;
            if (bit_ff == 3'd0) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.pixel_out  = quot_ff;
               rsp_data_in.frame_last = frame_last;
               pending_in             = pending_ff - PEND_W'(1);
               if (col_inc >= {1'b0, eff_w}) begin
                  out_col_in = '0;
                  if (row_inc >= {1'b0, eff_h}) begin
                     out_row_in = '0;
                  end else begin
                     out_row_in = row_inc[HEIGHT_W-1:0];
                  end
               end else begin
                  out_col_in = col_inc[WIDTH_W-1:0];
                  if (out_row_ff >= eff_h) begin
                     out_row_in = '0;
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         wr_addr_ff    <= '0;
         pending_ff    <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         cmp_valid_ff  <= 1'b0;
         issue_done_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wr_addr_ff    <= wr_addr_in;
         pending_ff    <= pending_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
         rsp_valid_ff  <= rsp_valid_in;
         cmp_valid_ff  <= cmp_valid_in;
         issue_done_ff <= issue_done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      base_ff      <= base_in;
      row_start_ff <= row_start_in;
      addr_ff      <= addr_in;
      win_col_ff   <= win_col_in;
      win_row_ff   <= win_row_in;
      centre_ff    <= centre_in;
      count_ff     <= count_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      bit_ff       <= bit_in;
      interior_ff  <= interior_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // line store write port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr_ff] <= req_data.pixel_in;
      end
   end

   // line store read port
   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   // checks
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= PEND_W'(DEPTH))
      else $error("pending count above store depth");

   a_addr_bound: assert property (@(posedge clock) disable iff (reset)
      (wr_addr_ff < ADDR_W'(DEPTH)) && (!mem_re || (mem_raddr < ADDR_W'(DEPTH))))
      else $error("store address out of range");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WIN) |-> (count_ff <= n_win))
      else $error("window count above window size");

   a_pixel_pending: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_data.op == OP_PIXEL) |=> (pending_ff != '0))
      else $error("pixel transfer left nothing pending");

   a_emit_has_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |-> (pending_ff != '0))
      else $error("result with nothing pending");

endmodule

// ===== verif/local_histogram_equalize_core_tb.sv =====
`timescale 1ns / 1ps
module local_histogram_equalize_core_tb;
   import lhe_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 300;

   // predictor state
   logic [7:0] pixel_store [DEPTH];
   int         store_wr;
   int         pixels_waiting;
   int         out_col;
   int         out_row;
   int         reg_width;
   int         reg_height;
   int         reg_radius;
   rsp_type    expected_pixels [$];

   int         error_count;
   int         idle_cycles;
   bit         quiet_mode;

   local_histogram_equalize_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int gap_length();
      int roll;
      if (quiet_mode) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int eff_width();
      if (reg_width == 0) return 1;
      if (reg_width > MAX_WIDTH) return MAX_WIDTH;
      return reg_width;
   endfunction

   function automatic int eff_height();
      return (reg_height == 0) ? 1 : reg_height;
   endfunction

   function automatic bit out_interior(int w, int h, int m);
      return out_row >= m && out_row < h - m && out_col >= m && out_col < w - m;
   endfunction

   // equalise the oldest waiting pixel and queue the expected result
   function automatic void equalize_pixel(int w, int h, int m);
      int       base;
      int       addr;
      int       count;
      int       n;
      int       val;
      logic [7:0] centre;
      rsp_type  r;
      base   = (store_wr - pixels_waiting + DEPTH) % DEPTH;
      centre = pixel_store[base];
      val    = centre;
      if (out_interior(w, h, m)) begin
         count = 0;
         n     = (2 * m + 1) * (2 * m + 1);
         for (int dr = -m; dr <= m; dr++) begin
            for (int dc = -m; dc <= m; dc++) begin
               addr = (base + dr * w + dc + DEPTH) % DEPTH;
               if (pixel_store[addr] <= centre) count++;
            end
         end
         val = (255 * count) / n;
      end
      r.pixel_out  = val[7:0];
      r.frame_last = (out_row == h - 1 && out_col == w - 1);
      expected_pixels.push_back(r);
      pixels_waiting--;
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
      end
      if (out_row >= h) out_row = 0;
   endfunction

   function automatic void predict_item(req_type item);
      int w;
      int h;
      int m;
      int lag;
      w   = eff_width();
      h   = eff_height();
      m   = reg_radius;
      lag = m * w + m;
      if (item.op == OP_PIXEL) begin
         pixel_store[store_wr] = item.pixel_in;
         store_wr = (store_wr + 1) % DEPTH;
         if (pixels_waiting < DEPTH) pixels_waiting++;
         if (pixels_waiting > lag) equalize_pixel(w, h, m);
      end else if (pixels_waiting > 0 &&
                   (pixels_waiting > lag || !out_interior(w, h, m))) begin
         equalize_pixel(w, h, m);
      end
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      error_count++;
   endtask

   // one input transfer, then a random gap
   task automatic send_item(logic op, logic [7:0] pix);
      req_type item;
      int      gap;
      item.op       = op;
      item.pixel_in = pix;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      predict_item(item);
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_pixel(logic [7:0] pix);
      send_item(OP_PIXEL, pix);
   endtask

   // push drains until every received pixel is out
   task automatic flush_frame();
      while (pixels_waiting > 0) send_item(OP_DRAIN, 8'($urandom));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH) reg_width = value & 'h7ff;
      else if (idx == CSR_IMAGE_HEIGHT) reg_height = value & 'hfff;
      else if (idx == CSR_WINDOW_RADIUS) reg_radius = value & 'h7;
   endtask

   task automatic set_frame(int w, int h, int m);
      flush_frame();
      wait_idle();
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_IMAGE_HEIGHT, h);
      write_csr(CSR_WINDOW_RADIUS, m);
   endtask

   // a single pixel on a 1x1 frame wraps the output position back to the origin
   task automatic realign_frame();
      set_frame(1, 1, 0);
      send_pixel(8'($urandom));
      flush_frame();
   endtask

   // whole frame of pixels, optionally with stray drains in between
   task automatic send_frame(int value_mode, int drain_pct);
      int total;
      logic [7:0] pix;
      total = eff_width() * eff_height();
      for (int i = 0; i < total; i++) begin
         if ($urandom_range(0, 99) < drain_pct) send_item(OP_DRAIN, 8'($urandom));
         case (value_mode)
            0: pix = 8'($urandom);
            1: pix = $urandom_range(0, 1) ? 8'hff : 8'h00;
            default: pix = 8'($urandom_range(0, 3));
         endcase
         send_pixel(pix);
      end
   endtask

   // extremes of pixel values on a 5x5 frame, plus a drain with nothing waiting
   task automatic test_directed();
      logic [7:0] pattern [25];
      set_frame(5, 5, 1);
      send_item(OP_DRAIN, 8'hff);
      for (int i = 0; i < 25; i++) pattern[i] = (i % 3 == 0) ? 8'hff : 8'(i * 17);
      pattern[12] = 8'h00;
      pattern[6]  = 8'h80;
      for (int i = 0; i < 25; i++) send_pixel(pattern[i]);
      flush_frame();
      send_item(OP_DRAIN, 8'h00);
   endtask

   // register values outside the usable range and at its ends, on short runs
   task automatic test_register_limits();
      set_frame(0, 0, 0);
      send_frame(0, 0);
      set_frame(2047, 1, 0);
      for (int i = 0; i < 24; i++) send_pixel(8'($urandom));
      realign_frame();
      set_frame(1, 4095, 1);
      quiet_mode = 1'b1;
      for (int i = 0; i < 30; i++) send_pixel($urandom_range(0, 1) ? 8'hff : 8'h00);
      quiet_mode = 1'b0;
      realign_frame();
      set_frame(1024, 1, 7);
      for (int i = 0; i < 24; i++) send_pixel(8'($urandom));
      realign_frame();
   endtask

   // widest window on a 16x15 frame, one column over the smallest that has interior pixels
   task automatic test_largest_window();
      set_frame(16, 15, 7);
      send_frame(2, 0);
   endtask

   // random frame shapes and content, stray drains, back to back frames
   task automatic test_random_frames();
      int sent;
      int w;
      int h;
      sent = 0;
      while (sent < 120) begin
         w = $urandom_range(1, 14);
         h = $urandom_range(1, 10);
         set_frame(w, h, $urandom_range(0, 3));
         quiet_mode = ($urandom_range(0, 4) == 0);
         repeat ($urandom_range(1, 2)) begin
            send_frame($urandom_range(0, 2), ($urandom_range(0, 3) == 0) ? 5 : 0);
            sent += w * h;
         end
         quiet_mode = 1'b0;
      end
      flush_frame();
   endtask

   // result checking and random back-pressure
   int stall_hold;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("result transfer with nothing expected");
            end else begin
               rsp_type e;
               e = expected_pixels.pop_front();
               if (rsp_data.pixel_out !== e.pixel_out)
                  report_mismatch($sformatf("pixel_out %0d, expected %0d",
                                            rsp_data.pixel_out, e.pixel_out));
               if (rsp_data.frame_last !== e.frame_last)
                  report_mismatch($sformatf("frame_last %0b, expected %0b",
                                            rsp_data.frame_last, e.frame_last));
            end
         end
         if (stall_hold > 0) begin
            stall_hold--;
         end else begin
            stall_hold = gap_length();
            rsp_stall <= (stall_hold > 0);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("local_histogram_equalize_core verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      error_count    = 0;
      idle_cycles    = 0;
      quiet_mode     = 1'b0;
      store_wr       = 0;
      pixels_waiting = 0;
      out_col        = 0;
      out_row        = 0;
      reg_width      = 640;
      reg_height     = 480;
      reg_radius     = 1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_register_limits();
      test_largest_window();
      test_random_frames();
      wait_idle();

      if (error_count == 0) begin
         $display("local_histogram_equalize_core verification clean");
      end else begin
         $display("local_histogram_equalize_core verification failed");
      end
      $finish;
   end

endmodule

// ===== local_histogram_equalize_core.f =====
rtl/lhe_pkg.sv
rtl/local_histogram_equalize_core.sv
verif/local_histogram_equalize_core_tb.sv
